/* hdl/csgf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csgf_pkg;

	// default depth of the character store
	localparam int unsigned CAPACITY_DEF = 16;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned COUNT_W = 5;

	// command codes
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_SWAP = 2'd1,
		OP_POP  = 2'd2,
		OP_LIST = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOMATCH = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// one result word
	typedef struct packed {
		status_t             status;
		logic [CHAR_W-1:0]   char_out;
		logic                last;
		logic [COUNT_W-1:0]  count;
	} res_t;

endpackage

`default_nettype wire

/* hdl/csgf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module csgf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read data holds while no read is issued
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/csgf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module csgf_ctrl #(
	parameter int unsigned CAPACITY = csgf_pkg::CAPACITY_DEF,
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned CW = $clog2(CAPACITY + 1),
	localparam int unsigned XW = CW + 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// command side
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire logic [1:0]                  opcode,
	input  wire logic [csgf_pkg::CHAR_W-1:0] char_in,
	// result side
	input  wire logic                        res_ready,
	output logic                             res_valid,
	output csgf_pkg::res_t                   res,
	// store port
	output logic                             ram_wr_en,
	output logic [AW-1:0]                    ram_wr_addr,
	output logic [csgf_pkg::CHAR_W-1:0]      ram_wr_data,
	output logic                             ram_rd_en,
	output logic [AW-1:0]                    ram_rd_addr,
	input  wire logic [csgf_pkg::CHAR_W-1:0] ram_rd_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LIST
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               top_q;
	logic [AW-1:0]               idx_q;
	logic [csgf_pkg::CHAR_W-1:0] char_q;

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic [CW-1:0]               top_inc;
	logic [CW-1:0]               top_dec;
	logic                        at_end;
	logic                        gt;
	logic [AW-1:0]               idx_inc;
	csgf_pkg::op_t               op;

	assign op        = csgf_pkg::op_t'(opcode);
	assign cmd_ready = (state_q == S_IDLE) && res_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign full      = (top_q == CW'(CAPACITY));
	assign empty     = (top_q == '0);
	assign top_inc   = top_q + CW'(1);
	assign top_dec   = top_q - CW'(1);
	assign idx_inc   = idx_q + AW'(1);
	// entry under test is the last held one
	assign at_end    = ((XW'(idx_q) + XW'(1)) == XW'(top_q));
	// compare unit for the swap scan, unsigned
	assign gt        = (ram_rd_data > char_q);

	always_comb begin
		res_valid   = 1'b0;
		res         = '0;
		res.count   = csgf_pkg::COUNT_W'(top_q);
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						csgf_pkg::OP_PUSH: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							if (!full) begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = top_q[AW-1:0];
								ram_wr_data = char_in;
								res.status  = csgf_pkg::ST_OK;
								res.count   = csgf_pkg::COUNT_W'(top_inc);
							end else begin
								res.status  = csgf_pkg::ST_FULL;
							end
						end
						csgf_pkg::OP_POP: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							if (!empty) begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = top_dec[AW-1:0];
								ram_wr_data = '0;
								res.status  = csgf_pkg::ST_OK;
								res.count   = csgf_pkg::COUNT_W'(top_dec);
							end else begin
								res.status  = csgf_pkg::ST_EMPTY;
							end
						end
						csgf_pkg::OP_SWAP: begin
							if (empty) begin
								res_valid  = 1'b1;
								res.last   = 1'b1;
								res.status = csgf_pkg::ST_NOMATCH;
							end else begin
								ram_rd_en = 1'b1;
							end
						end
						csgf_pkg::OP_LIST: begin
							if (empty) begin
								res_valid  = 1'b1;
								res.last   = 1'b1;
								res.status = csgf_pkg::ST_EMPTY;
							end else begin
								ram_rd_en = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (gt) begin
					if (res_ready) begin
						res_valid    = 1'b1;
						res.last     = 1'b1;
						res.status   = csgf_pkg::ST_OK;
						res.char_out = ram_rd_data;
						ram_wr_en    = 1'b1;
						ram_wr_addr  = idx_q;
						ram_wr_data  = char_q;
					end
				end else if (at_end) begin
					if (res_ready) begin
						res_valid  = 1'b1;
						res.last   = 1'b1;
						res.status = csgf_pkg::ST_NOMATCH;
					end
				end else begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = idx_inc;
				end
			end
			S_LIST: begin
				if (res_ready) begin
					res_valid    = 1'b1;
					res.last     = at_end;
					res.status   = csgf_pkg::ST_OK;
					res.char_out = ram_rd_data;
					if (!at_end) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = idx_inc;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= '0;
			idx_q   <= '0;
			char_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						char_q <= char_in;
						idx_q  <= '0;
						unique case (op)
							csgf_pkg::OP_PUSH: begin
								if (!full) begin
									top_q <= top_inc;
								end
							end
							csgf_pkg::OP_POP: begin
								if (!empty) begin
									top_q <= top_dec;
								end
							end
							csgf_pkg::OP_SWAP: begin
								if (!empty) begin
									state_q <= S_SCAN;
								end
							end
							csgf_pkg::OP_LIST: begin
								if (!empty) begin
									state_q <= S_LIST;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (gt || at_end) begin
						if (res_ready) begin
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_LIST: begin
					if (res_ready) begin
						if (at_end) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/char_stack_swap_first_greater_core.sv */
// bounded character stack with push, pop, list and swap-first-greater
// command channel (cmd_valid/cmd_ready): one word carries opcode and char_in
// result channel (rsp_valid/rsp_ready): one word carries status, char_out,
// last and count; last marks the final result word of a command
// every result word passes through one output register, so it shows on the
// outputs from the cycle after the sequencer produces it
// push and pop each give one result word
// swap walks the held entries from slot 0 through one store read port and
// one byte comparator, one entry a cycle, until the match or the last held
// entry; list sends one result word a cycle while the receiver takes them,
// one word per held entry; on an empty stack both give one failure word
// a new command is taken only while the sequencer is idle and the result
// register is free or being drained in the same cycle
// when the receiver stalls the result register holds its word and the
// sequencer waits in place; the store read data is held meanwhile
// reset empties the stack at once (count zero); store contents are never
// read above the top, so the store itself needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module char_stack_swap_first_greater_core #(
	parameter int unsigned CAPACITY = csgf_pkg::CAPACITY_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// command channel
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	input  wire logic [1:0]                   opcode,
	input  wire logic [csgf_pkg::CHAR_W-1:0]  char_in,
	// result channel
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output logic [1:0]                        status,
	output logic [csgf_pkg::CHAR_W-1:0]       char_out,
	output logic                              last,
	output logic [csgf_pkg::COUNT_W-1:0]      count
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// sequencer to result register
	logic                        res_valid;
	logic                        res_ready;
	csgf_pkg::res_t              res;

	// store port
	logic                        ram_wr_en;
	logic [AW-1:0]               ram_wr_addr;
	logic [csgf_pkg::CHAR_W-1:0] ram_wr_data;
	logic                        ram_rd_en;
	logic [AW-1:0]               ram_rd_addr;
	logic [csgf_pkg::CHAR_W-1:0] ram_rd_data;

	// result register
	logic                        rsp_valid_q;
	csgf_pkg::res_t              rsp_q;

	// slot is free when empty or drained this cycle
	assign res_ready = !rsp_valid_q || rsp_ready;

	csgf_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.opcode      (opcode),
		.char_in     (char_in),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	// character store, one write and one registered read per cycle
	csgf_ram #(
		.WIDTH (csgf_pkg::CHAR_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only when the slot is free
	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_q.status;
	assign char_out  = rsp_q.char_out;
	assign last      = rsp_q.last;
	assign count     = rsp_q.count;

endmodule

`default_nettype wire

/* hdl/csgf_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module csgf_chk #(
	parameter int unsigned CAPACITY = csgf_pkg::CAPACITY_DEF
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cmd_valid,
	input wire logic                        cmd_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [1:0]                  status,
	input wire logic [csgf_pkg::CHAR_W-1:0] char_out,
	input wire logic                        last,
	input wire logic [csgf_pkg::COUNT_W-1:0] count
);

	// a command is taken only when the result slot can take its word
	a_cmd_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> !rsp_valid || rsp_ready)
		else $error("command taken while result slot blocked");

	// stalled word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	// stalled word keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(char_out)
			&& $stable(last) && $stable(count))
		else $error("result payload changed while stalled");

	// any failure status is a lone final word with no character
	a_fail_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != csgf_pkg::ST_OK) |-> last && (char_out == '0))
		else $error("failure word malformed");

	// full report only when the stack is at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == csgf_pkg::ST_FULL)
			|-> (count == csgf_pkg::COUNT_W'(CAPACITY)))
		else $error("full status with stack below capacity");

endmodule

bind char_stack_swap_first_greater_core csgf_chk #(
	.CAPACITY (CAPACITY)
) u_csgf_chk (.*);

`default_nettype wire
